FILE: sv/lmc8_pkg.sv
// Package for the eight-neighbor local maximum counter.
// Holds default sizes, the configuration register map and the neighbor offsets.
// No dependencies.
`default_nettype none

package lmc8_pkg;

  localparam int MAX_COLS_DEF    = 512;
  localparam int MAX_ROWS_DEF    = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  // Width of the frame count result and of the size registers on the port.
  localparam int COUNT_BITS   = 19;
  localparam int CFG_BITS     = 10;
  localparam int CFG_IDX_BITS = 2;

  localparam int NEIGHBORS = 8;

  // Row and column offsets of the eight neighbors, clockwise from upper left.
  localparam int ROW_STEP [NEIGHBORS] = '{-1, -1, -1, 0, 1, 1, 1, 0};
  localparam int COL_STEP [NEIGHBORS] = '{-1, 0, 1, 1, 1, 0, -1, -1};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_ROWS = 2'd0,
    CFG_FRAME_COLS = 2'd1
  } cfg_reg_e;

  // Position flags of an item, captured at accept time.
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

`default_nettype wire

FILE: sv/lmc8_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lmc8_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/local_maxima_counter_8n.sv
// Eight-neighbor local maximum counter over a row-major frame of signed samples.
// Throughput: one item per cycle. A frame-ending item is held off only while both
// result slots would be full in the next cycle (short frames under output stall).
// The count passes from stage 1 into the head result slot, or the skid slot behind it.
// Both line stores share one RAM (read at accept, written back in the next cycle).
// Reset: sizes 1x1, position and count zero, no pending result; RAM not cleared.
`default_nettype none

module local_maxima_counter_8n
  import lmc8_pkg::*;
#(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic             [COUNT_BITS-1:0]  maxima_count_o,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic        [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic        [CFG_BITS-1:0]     cfg_data_i
);

  localparam int AW   = $clog2(MAX_COLS);
  localparam int RPW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RSW  = $clog2(MAX_ROWS + 1);
  localparam int CSW  = $clog2(MAX_COLS + 1);
  localparam int SZW  = (RSW > CSW) ? RSW : CSW;
  localparam int CMPW = (SZW > CFG_BITS) ? SZW : CFG_BITS;
  localparam int EW   = 2 * SAMPLE_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic signed [SAMPLE_BITS-1:0] win_t [3][3];

  // ---------------------------------------------------------------------------
  // Configuration and frame position
  // ---------------------------------------------------------------------------
  logic [RSW-1:0] rows_q, rows_d;
  logic [CSW-1:0] cols_q, cols_d;
  logic [RPW-1:0] row_pos_q, row_pos_d;
  logic [AW-1:0]  col_pos_q, col_pos_d;
  logic           cfg_hit;
  logic [CMPW-1:0] cfg_ext;
  logic           last_col_in, last_row_in, frame_last_in;
  logic           in_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = CMPW'(cfg_data_i);

  always_comb begin
    rows_d  = rows_q;
    cols_d  = cols_q;
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_ROWS: begin
          cfg_hit = 1'b1;
          if (cfg_ext == '0) begin
            rows_d = RSW'(1);
          end else if (cfg_ext > CMPW'(MAX_ROWS)) begin
            rows_d = RSW'(MAX_ROWS);
          end else begin
            rows_d = RSW'(cfg_ext);
          end
        end
        CFG_FRAME_COLS: begin
          cfg_hit = 1'b1;
          if (cfg_ext == '0) begin
            cols_d = CSW'(1);
          end else if (cfg_ext > CMPW'(MAX_COLS)) begin
            cols_d = CSW'(MAX_COLS);
          end else begin
            cols_d = CSW'(cfg_ext);
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  assign last_col_in   = (CSW'(col_pos_q) + CSW'(1)) == cols_q;
  assign last_row_in   = (RSW'(row_pos_q) + RSW'(1)) == rows_q;
  assign frame_last_in = last_col_in && last_row_in;

  // ---------------------------------------------------------------------------
  // Stage 1 registers (item whose line store entry is being read)
  // ---------------------------------------------------------------------------
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [AW-1:0]                 s1_addr_q;
  pos_flags_t                    s1_flags_q;
  logic                          s1_fwd_q;
  logic [EW-1:0]                 s1_fwd_data_q;
  logic                          s1_frame_last;
  logic                          out_valid_q;
  logic [COUNT_BITS-1:0]         out_count_q;
  logic                          skid_valid_q;
  logic [COUNT_BITS-1:0]         skid_count_q;
  logic                          out_push;
  logic                          out_pop;
  logic [1:0]                    out_fill;

  assign s1_frame_last = s1_flags_q.last_col && s1_flags_q.last_row;

  // Two result slots: head drives the port, skid catches a count behind it.
  assign out_push = s1_valid_q && s1_frame_last;
  assign out_pop  = out_valid_q && !out_stall_i;
  assign out_fill = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(out_push) - 2'(out_pop);

  // A frame-ending item needs a free result slot in the cycle after accept.
  assign in_stall_o = frame_last_in && (out_fill >= 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (cfg_hit) begin
      col_pos_d = '0;
      row_pos_d = '0;
    end else if (in_acc) begin
      if (!last_col_in) begin
        col_pos_d = col_pos_q + AW'(1);
      end else begin
        col_pos_d = '0;
        row_pos_d = last_row_in ? '0 : row_pos_q + RPW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: entry = {row above the previous row, previous row}
  // ---------------------------------------------------------------------------
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] entry;
  logic [EW-1:0] wr_data;
  logic          fwd_hit;
  logic signed [SAMPLE_BITS-1:0] above2, above1;

  lmc8_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (in_acc),
    .raddr_i (col_pos_q),
    .rdata_o (ram_rdata)
  );

  // Same entry read while the previous item writes it back (single-column frames).
  assign fwd_hit = s1_valid_q && (s1_addr_q == col_pos_q);
  assign entry   = s1_fwd_q ? s1_fwd_data_q : ram_rdata;
  assign above2  = entry[EW-1:SAMPLE_BITS];
  assign above1  = entry[SAMPLE_BITS-1:0];
  assign wr_data = {above1, s1_sample_q};

  // ---------------------------------------------------------------------------
  // Window shift and peak test
  // ---------------------------------------------------------------------------
  win_t win_q, win_d;

  function automatic logic is_peak(input win_t w, input int ri, input int ci,
                                   input logic [2:0] rok, input logic [2:0] cok);
    int   nr;
    int   nc;
    logic pk;
    pk = 1'b1;
    for (int k = 0; k < NEIGHBORS; k++) begin
      nr = ri + ROW_STEP[k];
      nc = ci + COL_STEP[k];
      if (nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2) begin
        if (rok[nr] && cok[nc] && (w[nr][nc] > w[ri][ci])) begin
          pk = 1'b0;
        end
      end
    end
    return pk;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = above2;
    win_d[1][2] = above1;
    win_d[2][2] = s1_sample_q;
  end

  logic [2:0]            rok, cok;
  logic                  p11, p12, p21, p22;
  logic [2:0]            n_hits;
  logic [COUNT_BITS:0]   sum_w;
  logic [COUNT_BITS-1:0] count_q, count_d, count_new;

  assign rok = {1'b1, s1_flags_q.r_ge1, s1_flags_q.r_ge2};
  assign cok = {1'b1, s1_flags_q.c_ge1, s1_flags_q.c_ge2};

  assign p11 = s1_flags_q.r_ge1 && s1_flags_q.c_ge1 && is_peak(win_d, 1, 1, rok, cok);
  assign p12 = s1_flags_q.r_ge1 && s1_flags_q.last_col && is_peak(win_d, 1, 2, rok, cok);
  assign p21 = s1_flags_q.last_row && s1_flags_q.c_ge1 && is_peak(win_d, 2, 1, rok, cok);
  assign p22 = s1_flags_q.last_row && s1_flags_q.last_col && is_peak(win_d, 2, 2, rok, cok);

  assign n_hits    = 3'(p11) + 3'(p12) + 3'(p21) + 3'(p22);
  assign sum_w     = {1'b0, count_q} + (COUNT_BITS + 1)'(n_hits);
  assign count_new = sum_w[COUNT_BITS] ? COUNT_MAX : sum_w[COUNT_BITS-1:0];

  always_comb begin
    count_d = count_q;
    if (cfg_hit) begin
      count_d = '0;
    end else if (s1_valid_q) begin
      count_d = s1_frame_last ? '0 : count_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= RSW'(1);
      cols_q       <= CSW'(1);
      row_pos_q    <= '0;
      col_pos_q    <= '0;
      count_q      <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      row_pos_q  <= row_pos_d;
      col_pos_q  <= col_pos_d;
      count_q    <= count_d;
      s1_valid_q <= in_acc;
      if (!out_valid_q || out_pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= out_push;
        end else begin
          out_valid_q <= out_push;
        end
      end else if (out_push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q         <= sample_i;
      s1_addr_q           <= col_pos_q;
      s1_fwd_q            <= fwd_hit;
      s1_fwd_data_q       <= wr_data;
      s1_flags_q.r_ge1    <= row_pos_q != '0;
      s1_flags_q.r_ge2    <= {1'b0, row_pos_q} >= (RPW + 1)'(2);
      s1_flags_q.c_ge1    <= col_pos_q != '0;
      s1_flags_q.c_ge2    <= col_pos_q >= AW'(2);
      s1_flags_q.last_col <= last_col_in;
      s1_flags_q.last_row <= last_row_in;
    end
    if (s1_valid_q) begin
      win_q <= win_d;
    end
    if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_count_q <= skid_count_q;
        if (out_push) begin
          skid_count_q <= count_new;
        end
      end else if (out_push) begin
        out_count_q <= count_new;
      end
    end else if (out_push) begin
      skid_count_q <= count_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign maxima_count_o = out_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && skid_valid_q) |-> out_pop)
    else $error("frame count overwrites a pending result");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CSW'(col_pos_q) < cols_q)
    else $error("column position outside frame");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RSW'(row_pos_q) < rows_q)
    else $error("row position outside frame");

  a_fwd_single_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> (cols_q == CSW'(1)))
    else $error("line store forward with more than one column");

  a_out_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_frame_last))
    else $error("result without a frame end");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for local_maxima_counter_8n: random frames, sizes and handshake gaps,
// with a scoreboard class that predicts each frame's local maximum count.
// Depends on lmc8_pkg and the local_maxima_counter_8n RTL.
`default_nettype none

module tb_top;
  import lmc8_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 200;

  // indexes past the register map; writes there must be ignored
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_3 = 2'd3;

  // sample flavors for a frame
  localparam int FLAVOR_WIDE    = 0;
  localparam int FLAVOR_TIES    = 1;
  localparam int FLAVOR_EXTREME = 2;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  class maxima_scoreboard;
    int unsigned frame_rows;
    int unsigned frame_cols;
    sample_t     prev_line [MAX_COLS_DEF];
    sample_t     curr_line [MAX_COLS_DEF];
    sample_t     win [9];
    bit [2:0]    row_ok;
    bit [2:0]    col_ok;
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned running;
    count_t      frame_counts [$];
    int          errors;

    function new();
      frame_rows = 1;
      frame_cols = 1;
      for (int i = 0; i < MAX_COLS_DEF; i++) begin
        prev_line[i] = '0;
        curr_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      row_pos = 0;
      col_pos = 0;
      running = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      if (idx == CFG_FRAME_ROWS) begin
        frame_rows = clamp_size(val, MAX_ROWS_DEF);
        restart();
      end else if (idx == CFG_FRAME_COLS) begin
        frame_cols = clamp_size(val, MAX_COLS_DEF);
        restart();
      end
    endfunction

    // one window cell is a peak when no in-frame neighbor is strictly greater
    function void judge(int ri, int ci);
      bit peak;
      int dr;
      int dc;
      int nr;
      int nc;
      peak = 1'b1;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = ri + dr;
          nc = ci + dc;
          if ((dr != 0 || dc != 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2) begin
            if (row_ok[nr] && col_ok[nc] && win[nr*3+nc] > win[ri*3+ci]) peak = 1'b0;
          end
        end
      end
      if (peak && running < (2**COUNT_BITS - 1)) running++;
    endfunction

    function void note_sample(sample_t s);
      sample_t above2;
      sample_t above1;
      bit last_col;
      bit last_row;
      above2 = prev_line[col_pos];
      above1 = curr_line[col_pos];
      prev_line[col_pos] = above1;
      curr_line[col_pos] = s;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = s;
      last_col = (col_pos + 1 >= frame_cols);
      last_row = (row_pos + 1 >= frame_rows);
      row_ok = {1'b1, row_pos >= 1, row_pos >= 2};
      col_ok = {1'b1, col_pos >= 1, col_pos >= 2};
      if (row_pos >= 1 && col_pos >= 1) judge(1, 1);
      if (row_pos >= 1 && last_col) judge(1, 2);
      if (last_row && col_pos >= 1) judge(2, 1);
      if (last_row && last_col) judge(2, 2);
      if (!last_col) begin
        col_pos++;
      end else begin
        col_pos = 0;
        if (!last_row) begin
          row_pos++;
        end else begin
          frame_counts.push_back(count_t'(running));
          restart();
        end
      end
    endfunction

    function void check_count(count_t got);
      count_t want;
      if (frame_counts.size() == 0) begin
        errors++;
        $display("%0t unexpected maxima_count: expected none, got %0d", $time, got);
      end else begin
        want = frame_counts.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t maxima_count mismatch: expected %0d, got %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall;
  sample_t                 sample;
  logic                    out_valid;
  logic                    out_stall;
  count_t                  maxima_count;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    hold_on;

  maxima_scoreboard counts;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;

  local_maxima_counter_8n u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .maxima_count_o (maxima_count),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("local_maxima_counter_8n verification failed");
    $finish;
  end

  // result side: check accepted counts, then pick the next stall
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) counts.check_count(maxima_count);
      out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic sample_t pick_sample(int flavor);
    case (flavor)
      FLAVOR_TIES: return sample_t'($signed($urandom_range(4)) - 2);
      FLAVOR_EXTREME: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk_i); while (in_stall);
    counts.note_sample(v);
    items_sent++;
  endtask

  task automatic send_run(input int n, input int flavor);
    repeat (n) send_sample(pick_sample(flavor));
  endtask

  // wait until every frame count is back and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (counts.frame_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    counts.write_reg(idx, val);
  endtask

  task automatic hold_results(input int n);
    hold_on <= 1'b1;
    repeat (n) @(posedge clk_i);
    hold_on <= 1'b0;
  endtask

  initial begin
    int start;
    int rows;
    int cols;
    int area;
    counts = new();
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    sample    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FRAME_ROWS;
    cfg_data  <= '0;
    hold_on   <= 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 48;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size is 1x1: every item is a frame of its own
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    settle();
    // zero sizes fall back to 1
    write_reg(CFG_FRAME_ROWS, '0);
    write_reg(CFG_FRAME_COLS, '0);
    send_sample('0);
    settle();
    // 3x3: single peak in the middle, corners and edges lose to it
    write_reg(CFG_FRAME_ROWS, 10'd3);
    write_reg(CFG_FRAME_COLS, 10'd3);
    for (int k = 0; k < 9; k++) send_sample(k == 4 ? 16'sh7fff : 16'sh8000);
    // partial frame, dropped by the next write
    for (int k = 0; k < 4; k++) send_sample(sample_t'(k));
    settle();
    write_reg(CFG_FRAME_COLS, 10'd2);
    write_reg(CFG_UNUSED_2, 10'd5);
    write_reg(CFG_UNUSED_3, 10'h3ff);
    // flat 3x2 frame: ties never disqualify, so every cell counts
    repeat (6) send_sample(-16'sd1);
    settle();

    // long result hold on back-to-back 1x1 frames so the input backs up
    write_reg(CFG_FRAME_ROWS, 10'd1);
    write_reg(CFG_FRAME_COLS, 10'd1);
    fork
      hold_results(HOLD_CYCLES);
    join_none
    send_run(40, FLAVOR_WIDE);
    settle();

    // largest sizes via oversize writes, one frame each
    write_reg(CFG_FRAME_COLS, 10'd1);
    write_reg(CFG_FRAME_ROWS, 10'h3ff);
    send_run(MAX_ROWS_DEF, FLAVOR_WIDE);
    settle();
    write_reg(CFG_FRAME_ROWS, 10'd1);
    write_reg(CFG_FRAME_COLS, 10'd600);
    send_run(MAX_COLS_DEF, FLAVOR_TIES);
    settle();

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ((items_sent - start) * 3 / RANDOM_ITEMS)
        0:       begin send_idle_pct = 18; recv_idle_pct = 48; end
        1:       begin send_idle_pct = 48; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      settle();
      rows = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      cols = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      area = rows * cols;
      if ($urandom_range(1)) begin
        write_reg(CFG_FRAME_ROWS, CFG_BITS'(rows));
        write_reg(CFG_FRAME_COLS, CFG_BITS'(cols));
      end else begin
        write_reg(CFG_FRAME_COLS, CFG_BITS'(cols));
        write_reg(CFG_FRAME_ROWS, CFG_BITS'(rows));
      end
      if ($urandom_range(9) == 0) write_reg($urandom_range(1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                                            CFG_BITS'($urandom));
      repeat ($urandom_range(4, 1)) send_run(area, $urandom_range(2));
      // broken frame now and then; the next size write throws it away
      if (area > 1 && $urandom_range(7) == 0) send_run($urandom_range(area - 1, 1),
                                                       $urandom_range(2));
    end

    settle();
    if (counts.errors == 0 && counts.frame_counts.size() == 0) begin
      $display("local_maxima_counter_8n verification clean");
    end else begin
      $display("local_maxima_counter_8n verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
